// ===== rtl/core/twsm_pkg.sv =====
// ----------------------------------------------------------------------------
// twsm_pkg: shared types and constants of the two-wire measurement master
// Command codes, register indexes, conversion constants and the status
// structs passed between the sequencer, the converter and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package twsm_pkg;

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_START_TEMP = 2'd1;
    localparam logic [1:0] OP_START_HUM  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_POLL_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_POLL_INTERVAL = 2'd1;

    // configuration reset values
    localparam logic [15:0] POLL_LIMIT_RST    = 16'd1000;
    localparam logic [15:0] POLL_INTERVAL_RST = 16'd2000;

    // sensor command bytes
    localparam logic [7:0] CMD_TEMP = 8'h03;
    localparam logic [7:0] CMD_HUM  = 8'h05;

    // conversion constants; results are in 0.01 units after the final divide
    localparam int TEMP_OFFSET = 4000;
    localparam int RAW_CLAMP   = 4095;
    localparam int HUM_GAIN    = 405000;
    localparam int HUM_OFFSET  = 40000000;
    localparam int HUM_DIVISOR = 100000;

    // serial unit step counts: one multiplier bit, one quotient bit per cycle
    localparam int MUL_STEPS = 12;
    localparam int DIV_STEPS = 14;

    // fields produced by one bus tick
    typedef struct packed {
        logic        clock_level;
        logic        data_pull_low;
        logic        busy;
        logic        done;
        logic [15:0] raw_word;
        logic        was_humidity;
        logic [2:0]  error_flags;
    } twsm_step_t;

    // converter status toward the top level
    typedef struct packed {
        logic active;
        logic ready;
    } twsm_conv_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/twsm_seq.sv =====
// ----------------------------------------------------------------------------
// twsm_seq: bus phase sequencer
// Advances the sensor bus state by one tick per transfer: start pattern,
// serial command, acknowledge checks, data-ready polling, serial read-in.
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_seq
    import twsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [1:0]  operation,
    input  wire logic        data_level,
    input  wire logic [15:0] poll_limit,
    input  wire logic [15:0] poll_interval,
    output twsm_step_t       res
);

    typedef enum logic [19:0] {
        PH_IDLE     = 20'h00001,
        PH_ST0      = 20'h00002,
        PH_ST1      = 20'h00004,
        PH_ST2      = 20'h00008,
        PH_ST3      = 20'h00010,
        PH_ST4      = 20'h00020,
        PH_ST5      = 20'h00040,
        PH_CMD_LO   = 20'h00080,
        PH_CMD_HI   = 20'h00100,
        PH_CMD_TAIL = 20'h00200,
        PH_ACK_HI   = 20'h00400,
        PH_ACK_LO   = 20'h00800,
        PH_WAIT     = 20'h01000,
        PH_RD_HI    = 20'h02000,
        PH_RD_LO    = 20'h04000,
        PH_MACK0    = 20'h08000,
        PH_MACK1    = 20'h10000,
        PH_MACK2    = 20'h20000,
        PH_MACK3    = 20'h40000,
        PH_CRC      = 20'h80000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [15:0] shift_word_reg, shift_word_next;
    logic [15:0] poll_count_reg, poll_count_next;
    logic [15:0] interval_count_reg, interval_count_next;
    logic        measure_kind_reg, measure_kind_next;
    logic [2:0]  error_bits_reg, error_bits_next;

    logic [15:0] lim;
    logic [15:0] ivl;
    logic [15:0] interval_inc;
    logic [15:0] poll_inc;
    logic [7:0]  cmd_byte;
    logic        cmd_bit;
    logic        clk_lvl;
    logic        pull_lvl;

    // zero registers act as one
    assign lim          = (poll_limit == 16'd0) ? 16'd1 : poll_limit;
    assign ivl          = (poll_interval == 16'd0) ? 16'd1 : poll_interval;
    assign interval_inc = interval_count_reg + 16'd1;
    assign poll_inc     = poll_count_reg + 16'd1;

    // phase transitions for one tick
    always_comb begin
        phase_next          = phase_reg;
        bit_count_next      = bit_count_reg;
        shift_word_next     = shift_word_reg;
        poll_count_next     = poll_count_reg;
        interval_count_next = interval_count_reg;
        measure_kind_next   = measure_kind_reg;
        error_bits_next     = error_bits_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (operation == OP_START_TEMP || operation == OP_START_HUM) begin
                    measure_kind_next   = (operation == OP_START_HUM);
                    error_bits_next     = 3'd0;
                    bit_count_next      = 4'd0;
                    shift_word_next     = 16'd0;
                    poll_count_next     = 16'd0;
                    interval_count_next = 16'd0;
                    phase_next          = PH_ST0;
                end
            end
            PH_ST0:  phase_next = PH_ST1;
            PH_ST1:  phase_next = PH_ST2;
            PH_ST2:  phase_next = PH_ST3;
            PH_ST3:  phase_next = PH_ST4;
            PH_ST4:  phase_next = PH_ST5;
            PH_ST5: begin
                bit_count_next = 4'd0;
                phase_next     = PH_CMD_LO;
            end
            PH_CMD_LO: phase_next = PH_CMD_HI;
            PH_CMD_HI: begin
                if (bit_count_reg >= 4'd7) begin
                    phase_next = PH_CMD_TAIL;
                end else begin
                    bit_count_next = bit_count_reg + 4'd1;
                    phase_next     = PH_CMD_LO;
                end
            end
            PH_CMD_TAIL: phase_next = PH_ACK_HI;
            PH_ACK_HI: begin
                if (data_level) error_bits_next[0] = 1'b1;
                phase_next = PH_ACK_LO;
            end
            PH_ACK_LO: begin
                if (!data_level) error_bits_next[1] = 1'b1;
                poll_count_next     = 16'd0;
                interval_count_next = 16'd0;
                phase_next          = PH_WAIT;
            end
            PH_WAIT: begin
                // sample the data line once per poll interval
                if (interval_inc >= ivl) begin
                    interval_count_next = 16'd0;
                    poll_count_next     = poll_inc;
                    if (!data_level || poll_inc >= lim) begin
                        if (data_level) error_bits_next[2] = 1'b1;
                        bit_count_next  = 4'd0;
                        shift_word_next = 16'd0;
                        phase_next      = PH_RD_HI;
                    end
                end else begin
                    interval_count_next = interval_inc;
                end
            end
            PH_RD_HI: begin
                shift_word_next = {shift_word_reg[14:0], data_level};
                phase_next      = PH_RD_LO;
            end
            PH_RD_LO: begin
                if (bit_count_reg == 4'd7) begin
                    bit_count_next = 4'd8;
                    phase_next     = PH_MACK0;
                end else if (bit_count_reg >= 4'd15) begin
                    phase_next = PH_CRC;
                end else begin
                    bit_count_next = bit_count_reg + 4'd1;
                    phase_next     = PH_RD_HI;
                end
            end
            PH_MACK0: phase_next = PH_MACK1;
            PH_MACK1: phase_next = PH_MACK2;
            PH_MACK2: phase_next = PH_MACK3;
            PH_MACK3: phase_next = PH_RD_HI;
            PH_CRC:   phase_next = PH_IDLE;
            default:  phase_next = PH_IDLE;
        endcase
    end

    // command bit under the new bit count, msb first
    assign cmd_byte = measure_kind_next ? CMD_HUM : CMD_TEMP;
    assign cmd_bit  = cmd_byte[~bit_count_next[2:0]];

    // line levels driven in the new phase
    always_comb begin
        clk_lvl  = 1'b0;
        pull_lvl = 1'b0;
        unique case (phase_next)
            PH_ST0: begin clk_lvl = 1'b1; pull_lvl = 1'b0; end
            PH_ST1: begin clk_lvl = 1'b1; pull_lvl = 1'b1; end
            PH_ST2: begin clk_lvl = 1'b0; pull_lvl = 1'b1; end
            PH_ST3: begin clk_lvl = 1'b1; pull_lvl = 1'b1; end
            PH_ST4: begin clk_lvl = 1'b1; pull_lvl = 1'b0; end
            PH_CMD_LO, PH_CMD_TAIL: pull_lvl = !cmd_bit;
            PH_CMD_HI: begin clk_lvl = 1'b1; pull_lvl = !cmd_bit; end
            PH_ACK_HI, PH_RD_HI, PH_CRC: clk_lvl = 1'b1;
            PH_MACK0, PH_MACK2: pull_lvl = 1'b1;
            PH_MACK1: begin clk_lvl = 1'b1; pull_lvl = 1'b1; end
            default: begin clk_lvl = 1'b0; pull_lvl = 1'b0; end
        endcase
    end

    // tick result fields
    always_comb begin
        res.clock_level   = clk_lvl;
        res.data_pull_low = pull_lvl;
        res.busy          = (phase_next != PH_IDLE);
        res.done          = (phase_reg == PH_CRC);
        res.raw_word      = (phase_reg == PH_CRC) ? shift_word_next : 16'd0;
        res.was_humidity  = (phase_reg == PH_CRC) ? measure_kind_next : 1'b0;
        res.error_flags   = (phase_reg == PH_CRC) ? error_bits_next : 3'd0;
    end

    // state registers, advanced once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            bit_count_reg      <= 4'd0;
            shift_word_reg     <= 16'd0;
            poll_count_reg     <= 16'd0;
            interval_count_reg <= 16'd0;
            measure_kind_reg   <= 1'b0;
            error_bits_reg     <= 3'd0;
        end else if (step) begin
            phase_reg          <= phase_next;
            bit_count_reg      <= bit_count_next;
            shift_word_reg     <= shift_word_next;
            poll_count_reg     <= poll_count_next;
            interval_count_reg <= interval_count_next;
            measure_kind_reg   <= measure_kind_next;
            error_bits_reg     <= error_bits_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/twsm_conv.sv =====
// ----------------------------------------------------------------------------
// twsm_conv: serial result converter
// Temperature is raw minus offset, taken straight from idle to done. Humidity runs
// a shift-add multiply, one multiplier bit per cycle, then a restoring divide by a
// constant, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_conv
    import twsm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic               kind,
    input  wire logic [15:0]        raw,
    input  wire logic               take,
    output twsm_conv_stat_t         stat,
    output logic signed [16:0]      value
);

    typedef enum logic [5:0] {
        C_IDLE = 6'b000001,
        C_MUL  = 6'b000010,
        C_BIAS = 6'b000100,
        C_DIV  = 6'b001000,
        C_SIGN = 6'b010000,
        C_DONE = 6'b100000
    } conv_state_t;

    localparam logic [30:0] DIV_START = 31'(HUM_DIVISOR) << (DIV_STEPS - 1);
    localparam logic [30:0] OFFSET_W  = 31'(HUM_OFFSET);

    conv_state_t        state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [11:0]        mplier_reg, mplier_next;
    logic [30:0]        mcand_reg, mcand_next;
    logic [30:0]        acc_reg, acc_next;
    logic [30:0]        div_reg, div_next;
    logic [13:0]        quot_reg, quot_next;
    logic               neg_reg, neg_next;
    logic signed [16:0] value_reg, value_next;

    logic [11:0]        v_clamp;
    logic [16:0]        sq_term;
    logic [18:0]        gain_term;
    logic signed [16:0] temp_value;
    logic [30:0]        acc_sum;
    logic               rem_ge;
    logic signed [16:0] quot_s;

    // clamp, and the per-reading gain 405000 - 28v
    assign v_clamp    = (raw > 16'(RAW_CLAMP)) ? 12'(RAW_CLAMP) : raw[11:0];
    assign sq_term    = {v_clamp, 5'b0} - {3'b0, v_clamp, 2'b0};
    assign gain_term  = 19'(HUM_GAIN) - {2'b0, sq_term};
    assign temp_value = $signed({1'b0, raw}) - 17'(TEMP_OFFSET);

    // one shift-add step and one compare-subtract step
    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : 31'd0);
    assign rem_ge  = (acc_reg >= div_reg);
    assign quot_s  = $signed({3'b0, quot_reg});

    // converter sequence
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        div_next    = div_reg;
        quot_next   = quot_reg;
        neg_next    = neg_reg;
        value_next  = value_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    if (kind) begin
                        mplier_next = v_clamp;
                        mcand_next  = {12'd0, gain_term};
                        acc_next    = 31'd0;
                        cnt_next    = 4'd0;
                        state_next  = C_MUL;
                    end else begin
                        value_next = temp_value;
                        state_next = C_DONE;
                    end
                end
            end
            C_MUL: begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[29:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[11:1]};
                if (cnt_reg == 4'(MUL_STEPS - 1)) begin
                    state_next = C_BIAS;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            C_BIAS: begin
                // remove the offset as sign and magnitude
                if (acc_reg < OFFSET_W) begin
                    neg_next = 1'b1;
                    acc_next = OFFSET_W - acc_reg;
                end else begin
                    neg_next = 1'b0;
                    acc_next = acc_reg - OFFSET_W;
                end
                div_next   = DIV_START;
                quot_next  = 14'd0;
                cnt_next   = 4'd0;
                state_next = C_DIV;
            end
            C_DIV: begin
                if (rem_ge) acc_next = acc_reg - div_reg;
                quot_next = {quot_reg[12:0], rem_ge};
                div_next  = {1'b0, div_reg[30:1]};
                if (cnt_reg == 4'(DIV_STEPS - 1)) begin
                    state_next = C_SIGN;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            C_SIGN: begin
                value_next = neg_reg ? -quot_s : quot_s;
                state_next = C_DONE;
            end
            C_DONE: begin
                if (take) state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            cnt_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        div_reg    <= div_next;
        quot_reg   <= quot_next;
        neg_reg    <= neg_next;
        value_reg  <= value_next;
    end

    assign stat.active = (state_reg != C_IDLE);
    assign stat.ready  = (state_reg == C_DONE);
    assign value       = value_reg;

endmodule

`default_nettype wire

// ===== rtl/core/two_wire_sensor_measurement_master_unit.sv =====
// A plain tick's result is registered and shown in the cycle after the transfer.
// A completing tick waits for the converter: temperature goes straight to done,
// humidity runs 12 multiply steps, 1 offset step, 14 divide steps, 1 sign step.
// Throughput: one tick per cycle while no conversion runs and the output is free;
// input is held off while the converter works. Reset (aresetn low, synchronous)
// returns the bus sequencer to idle and loads poll_limit 1000, poll_interval 2000.
// ----------------------------------------------------------------------------
// two_wire_sensor_measurement_master_unit: two-wire sensor measurement master
// Stream wrapper around the bus sequencer and the serial converter, with
// the configuration registers and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wire_sensor_measurement_master_unit
    import twsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] data_level, [7:1] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] operation

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [0] clock_level, [1] data_pull_low,
                                        // [2] busy_res, [3] done_res,
                                        // [19:4] raw_word,
                                        // [36:20] converted_value,
                                        // [39:37] error_flags
    output logic [0:0]       m_tuser,   // [0] was_humidity

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0]        poll_limit_reg;
    logic [15:0]        poll_interval_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    twsm_step_t         out_step_reg;
    logic signed [16:0] out_value_reg;

    logic               s_xfer;
    logic               m_xfer;
    logic               slot_free;
    logic               conv_take;
    twsm_step_t         step_res;
    twsm_conv_stat_t    conv_stat;
    logic signed [16:0] conv_value;

    // handshake
    assign cfg_ready = 1'b1;
    assign m_xfer    = m_tvalid_reg && m_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = !conv_stat.active && slot_free;
    assign s_xfer    = s_tvalid && s_tready;
    assign conv_take = conv_stat.ready && slot_free;

    twsm_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (s_xfer),
        .operation     (s_tuser),
        .data_level    (s_tdata[0]),
        .poll_limit    (poll_limit_reg),
        .poll_interval (poll_interval_reg),
        .res           (step_res)
    );

    twsm_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_xfer && step_res.done),
        .kind    (step_res.was_humidity),
        .raw     (step_res.raw_word),
        .take    (conv_take),
        .stat    (conv_stat),
        .value   (conv_value)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg    <= POLL_LIMIT_RST;
            poll_interval_reg <= POLL_INTERVAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_POLL_LIMIT)    poll_limit_reg    <= cfg_data;
            if (cfg_index == CFG_POLL_INTERVAL) poll_interval_reg <= cfg_data;
        end
    end

    // output valid: plain ticks at once, completing ticks after conversion
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_xfer) m_tvalid_next = 1'b0;
        if (s_xfer && !step_res.done) m_tvalid_next = 1'b1;
        if (conv_take) m_tvalid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_step_reg  <= step_res;
            out_value_reg <= 17'sd0;
        end
        if (conv_take) out_value_reg <= conv_value;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_step_reg.error_flags, out_value_reg, out_step_reg.raw_word,
                       out_step_reg.done, out_step_reg.busy,
                       out_step_reg.data_pull_low, out_step_reg.clock_level};
    assign m_tuser  = out_step_reg.was_humidity;

    // no input transfer while a conversion runs
    a_hold_while_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_stat.active |-> !s_tready)
        else $error("input taken during conversion");

    // a completing tick never shows its result on the next edge
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && step_res.done) |=> !m_tvalid_reg)
        else $error("completion result shown before conversion");

    // a waiting result and a running conversion exclude each other
    a_one_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !conv_stat.active)
        else $error("result pending while converter busy");

endmodule

`default_nettype wire
